[src/assert_macros.svh]
// Assertion macros for the haze recovery block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HPR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed");
`define HPR_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition");
`else
`define HPR_ASSERT(lbl, clk, rst_n, prop)
`define HPR_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[src/hpr_pkg.sv]
// Types and constants for the haze pixel recovery block.
// No dependencies.
package hpr_pkg;
	localparam int unsigned OneQ16 = 65536;
	localparam logic [7:0] AMin = 8'd150;
	localparam logic [7:0] ChMax = 8'd255;
	localparam logic [7:0] AtmosReset = 8'd255;
	localparam logic [15:0] KeepReset = 16'd58982;
	localparam logic [15:0] FloorReset = 16'd13107;

	typedef enum logic [1:0] {
		REG_ATMOS = 2'd0,
		REG_KEEP = 2'd1,
		REG_FLOOR = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] blue_in;
		logic [7:0] green_in;
		logic [7:0] red_in;
		logic [7:0] dark_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] blue_out;
		logic [7:0] green_out;
		logic [7:0] red_out;
		logic [16:0] transmission_out;
	} pix_out_t;
endpackage

[src/hpr_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband tag.
// Caller guarantees num < den * 2**QW. Uses no package items.
module hpr_div #(
	parameter int NW = 24,
	parameter int DW = 8,
	parameter int QW = 17,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	localparam int XW = NW + QW;

	logic          vld_s [QW+1];
	logic [NW-1:0] rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [TW-1:0] tag_s [QW+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign tag_s[0] = tag;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [XW-1:0] remx;
		logic [XW-1:0] dsh;
		logic [XW-1:0] diff;
		logic          ge;
		assign remx = {{QW{1'b0}}, rem_s[i]};
		assign dsh = {{(XW-DW){1'b0}}, den_s[i]} << (QW - 1 - i);
		assign ge = remx >= dsh;
		assign diff = remx - dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[NW-1:0] : rem_s[i];
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= {quo_s[i][QW-2:0], ge};
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quo = quo_s[QW];
	assign tag_out = tag_s[QW];
endmodule

[src/haze_pixel_recovery.sv]
// Haze pixel recovery: transmission from dark channel, then per-channel recovery.
// One beat per cycle sustained while the output is not stalled, set by the two
// bit-per-stage divider pipelines (17 and 8 stages).
// Whole pipeline holds when the output beat is stalled.
// Async active-low reset clears valid bits and loads register defaults.
`include "assert_macros.svh"
module haze_pixel_recovery (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hpr_pkg::pix_in_t  in_pixel,
	output logic              out_valid,
	input  logic              out_ready,
	output hpr_pkg::pix_out_t out_pixel,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	localparam int TagW = 26;

	logic [7:0]  atmos_q;
	logic [15:0] keep_q;
	logic [15:0] floor_q;
	logic [7:0]  a_eff;
	logic        en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atmos_q <= hpr_pkg::AtmosReset;
			keep_q <= hpr_pkg::KeepReset;
			floor_q <= hpr_pkg::FloorReset;
		end else if (cfg_valid) begin
			case (hpr_pkg::cfg_reg_t'(cfg_index))
				hpr_pkg::REG_ATMOS: atmos_q <= cfg_data[7:0];
				hpr_pkg::REG_KEEP: keep_q <= cfg_data;
				hpr_pkg::REG_FLOOR: floor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign a_eff = (atmos_q < hpr_pkg::AMin) ? hpr_pkg::AMin : atmos_q;

	// stage 1: weighted dark product
	logic              vld_s1;
	logic [23:0]       prod_s1;
	logic [23:0]       pix_s1;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= keep_q * in_pixel.dark_in;
			pix_s1 <= {in_pixel.blue_in, in_pixel.green_in, in_pixel.red_in};
		end
	end

	logic        dv_vld;
	logic [16:0] dv_quo;
	logic [23:0] dv_pix;

	hpr_div #(.NW(24), .DW(8), .QW(17), .TW(24)) u_tdiv (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s1), .num(prod_s1), .den(a_eff), .tag(pix_s1),
		.out_valid(dv_vld), .quo(dv_quo), .tag_out(dv_pix)
	);

	// stage 2: transmission and floor clamp
	logic        vld_s2;
	logic [16:0] t_s2;
	logic [23:0] pix_s2;
	logic [16:0] t_raw;

	assign t_raw = dv_quo[16] ? 17'd0 : (17'(hpr_pkg::OneQ16) - {1'b0, dv_quo[15:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2 <= (t_raw < {1'b0, floor_q}) ? {1'b0, floor_q} : t_raw;
			pix_s2 <= dv_pix;
		end
	end

	// stage 3: numerators
	logic               vld_s3;
	logic [16:0]        t_s3;
	logic [23:0]        pix_s3;
	logic signed [25:0] n_s3 [3];
	logic [24:0]        at;

	assign at = a_eff * t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3 <= t_s2;
			pix_s3 <= pix_s2;
		end
	end

	logic        ch_vld [3];
	logic [7:0]  ch_quo [3];
	logic [TagW-1:0] ch_tag [3];

	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic [7:0]        cv2;
		logic [7:0]        cv3;
		logic signed [8:0] diff;
		logic              force_res;
		logic [7:0]        force_val;
		logic [24:0]       num;

		assign cv2 = pix_s2[23-8*c -: 8];
		assign cv3 = pix_s3[23-8*c -: 8];
		assign diff = $signed({1'b0, cv2}) - $signed({1'b0, a_eff});

		always_ff @(posedge clk) begin
			if (en) begin
				n_s3[c] <= $signed({1'b0, at}) + $signed({diff[8], diff, 16'd0});
			end
		end

		always_comb begin
			force_res = 1'b0;
			force_val = 8'd0;
			if (t_s3 == 17'd0) begin
				force_res = 1'b1;
				if (cv3 < a_eff) force_val = 8'd0;
				else if (cv3 == a_eff) force_val = a_eff;
				else force_val = hpr_pkg::ChMax;
			end else if (n_s3[c] < 0) begin
				force_res = 1'b1;
				force_val = 8'd0;
			end else if (n_s3[c][24:0] >= {t_s3, 8'd0}) begin
				force_res = 1'b1;
				force_val = hpr_pkg::ChMax;
			end
		end

		assign num = force_res ? 25'd0 : n_s3[c][24:0];

		hpr_div #(.NW(25), .DW(17), .QW(8), .TW(TagW)) u_cdiv (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(vld_s3), .num(num), .den(t_s3),
			.tag({t_s3, force_res, force_val}),
			.out_valid(ch_vld[c]), .quo(ch_quo[c]), .tag_out(ch_tag[c])
		);
	end

	logic [7:0] ch_res [3];
	for (genvar c = 0; c < 3; c++) begin : g_res
		assign ch_res[c] = ch_tag[c][8] ? ch_tag[c][7:0] : ch_quo[c];
	end

	assign out_valid = ch_vld[0];
	assign out_pixel.blue_out = ch_res[0];
	assign out_pixel.green_out = ch_res[1];
	assign out_pixel.red_out = ch_res[2];
	assign out_pixel.transmission_out = ch_tag[0][25:9];

	`HPR_NEVER(a_out_t_range, clk, arst_n, out_valid && (out_pixel.transmission_out > 17'd65536))
	`HPR_NEVER(a_out_t_floor, clk, arst_n, out_valid && (out_pixel.transmission_out < {1'b0, floor_q}))
	`HPR_ASSERT(a_lanes_aligned, clk, arst_n, (ch_vld[0] == ch_vld[1]) && (ch_vld[0] == ch_vld[2]))
	`HPR_ASSERT(a_stall_holds, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_pixel))
endmodule

[tb/haze_pixel_recovery_checker.sv]
// Checker for haze_pixel_recovery: watches config, input and output beats.
// Predicts each recovered pixel and compares; depends on hpr_pkg.
`timescale 1ns / 100ps
module haze_pixel_recovery_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  hpr_pkg::pix_in_t  in_pixel,
	input  logic              out_valid,
	input  logic              out_ready,
	input  hpr_pkg::pix_out_t out_pixel,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output int                errors,
	output int                pending
);
	import hpr_pkg::*;

	logic [7:0] atmos;
	logic [15:0] keep;
	logic [15:0] floor_t;
	pix_out_t recovered_q[$];

	function automatic logic [7:0] recover_chan(logic [7:0] c, logic [7:0] a, logic [16:0] t);
		longint n;
		longint q;
		if (t == 0) begin
			if (c < a) return 8'd0;
			if (c == a) return a;
			return ChMax;
		end
		n = longint'(a) * longint'(t) + (longint'(c) - longint'(a)) * longint'(OneQ16);
		if (n < 0) return 8'd0;
		q = n / longint'(t);
		if (q > 255) q = 255;
		return q[7:0];
	endfunction

	function automatic pix_out_t recover_pixel(pix_in_t p);
		pix_out_t r;
		logic [7:0] a;
		longint q;
		longint t;
		a = (atmos < AMin) ? AMin : atmos;
		q = (longint'(keep) * longint'(p.dark_in)) / longint'(a);
		t = (q >= OneQ16) ? 0 : OneQ16 - q;
		if (t < floor_t) t = floor_t;
		r.transmission_out = t[16:0];
		r.blue_out = recover_chan(p.blue_in, a, t[16:0]);
		r.green_out = recover_chan(p.green_in, a, t[16:0]);
		r.red_out = recover_chan(p.red_in, a, t[16:0]);
		return r;
	endfunction

	assign pending = recovered_q.size();

	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			atmos <= AtmosReset;
			keep <= KeepReset;
			floor_t <= FloorReset;
			errors <= 0;
			recovered_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_ATMOS: atmos <= cfg_data[7:0];
					REG_KEEP: keep <= cfg_data;
					REG_FLOOR: floor_t <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				recovered_q.push_back(recover_pixel(in_pixel));
			if (out_valid && out_ready) begin
				if (recovered_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %h", $time, out_pixel);
					errors <= errors + 1;
				end else begin
					want = recovered_q.pop_front();
					if (want.blue_out !== out_pixel.blue_out
							|| want.green_out !== out_pixel.green_out
							|| want.red_out !== out_pixel.red_out
							|| want.transmission_out !== out_pixel.transmission_out) begin
						$display("%0t: mismatch expected b=%0d g=%0d r=%0d t=%0d actual b=%0d g=%0d r=%0d t=%0d",
							$time, want.blue_out, want.green_out, want.red_out,
							want.transmission_out, out_pixel.blue_out, out_pixel.green_out,
							out_pixel.red_out, out_pixel.transmission_out);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

[tb/haze_pixel_recovery_tb.sv]
// Top of the haze_pixel_recovery testbench: clock, reset, stimulus, verdict.
// Depends on hpr_pkg, haze_pixel_recovery and haze_pixel_recovery_checker.
`timescale 1ns / 100ps
module haze_pixel_recovery_tb;
	import hpr_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pix_in_t in_pixel = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pix_out_t out_pixel;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int errors;
	int pending;
	bit quiet = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	haze_pixel_recovery u_dut (.*);
	haze_pixel_recovery_checker u_chk (.*);

	initial begin
		#200_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// sink: random stall bursts, none once quiet
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 18);
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic [7:0] d);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_pixel <= '{blue_in: b, green_in: g, red_in: r, dark_in: d};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] a, logic [15:0] w, logic [15:0] f);
		drain();
		write_reg(REG_ATMOS, a);
		write_reg(REG_KEEP, w);
		write_reg(REG_FLOOR, f);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_pixels(int count);
		logic [7:0] a;
		for (int i = 0; i < count; i++) begin
			a = u_chk.atmos < AMin ? AMin : u_chk.atmos;
			if ($urandom_range(0, 5) == 0)
				send_pixel(a, a, a, 8'($urandom));
			else
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// default registers: extremes and the A point
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd128, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
		send_pixel(8'd170, 8'd85, 8'd1, 8'd200);
		// A below minimum acts as 150
		set_regs(16'd0, 16'd58982, 16'd13107);
		send_pixel(8'd150, 8'd149, 8'd151, 8'd100);
		send_pixel(8'd0, 8'd255, 8'd150, 8'd255);
		// zero transmission floor: t reaches zero
		set_regs(16'd150, 16'd65535, 16'd0);
		send_pixel(8'd149, 8'd150, 8'd151, 8'd150);
		send_pixel(8'd0, 8'd150, 8'd255, 8'd255);
		send_pixel(8'd10, 8'd200, 8'd150, 8'd149);
		// floor at max, weight zero
		set_regs(16'd255, 16'd0, 16'd65535);
		send_pixel(8'd0, 8'd255, 8'd100, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd200, 8'd0);
		set_regs(16'd200, 16'd65535, 16'd1);
		send_pixel(8'd0, 8'd255, 8'd200, 8'd255);
		send_pixel(8'd199, 8'd201, 8'd0, 8'd1);
		random_pixels(150);
		for (int ph = 0; ph < 6; ph++) begin
			set_regs(16'($urandom_range(0, 255)), 16'($urandom),
				($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom));
			random_pixels(150);
		end
		set_regs(16'd255, 16'd58982, 16'd13107);
		quiet = 1'b1;
		random_pixels(150);
		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
